[src/gdn_pkg.sv]
`timescale 1ns / 1ps
// Shared types, op codes and calendar helpers for the Gregorian day number converter.
// No dependencies.
package gdn_pkg;

  localparam logic [2:0]  OP_FROM_DATE = 3'd0;
  localparam logic [2:0]  OP_FROM_JDN  = 3'd1;
  localparam logic [2:0]  OP_ADD_MONTHS = 3'd2;
  localparam logic [2:0]  OP_ADD_YEARS = 3'd3;
  localparam logic [2:0]  OP_ADD_DAYS  = 3'd4;

  localparam logic [22:0] FIRST_JDN = 23'd1721426;
  localparam logic [22:0] LAST_JDN  = 23'd5373484;
  localparam logic [13:0] MAX_YEAR  = 14'd9999;

  typedef struct packed {
    logic [2:0]         op;
    logic [13:0]        year_in;
    logic [3:0]         month_in;
    logic [4:0]         day_in;
    logic [22:0]        day_number_in;
    logic signed [23:0] offset;
  } gdn_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [22:0] day_number_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic [4:0]  month_length;
    logic        leap;
  } gdn_out_t;

  typedef struct packed {
    logic        ok;
    logic [22:0] jd;
  } gdn_jd_t;

  function automatic logic is_leap(input logic [13:0] y);
    logic [30:0] p;
    logic [13:0] q;
    logic [13:0] back;
    logic        div25;
    p = 31'(y) * 31'd5243;
    q = p[30:17];
    back = 14'(q * 14'd25);
    div25 = (back == y);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [13:0] y, input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2: r = is_leap(y) ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // days from March 1 to the first of the month, months counted from March
  function automatic logic [8:0] mar_offset(input logic [3:0] mm);
    logic [8:0] r;
    case (mm)
      4'd0: r = 9'd0;
      4'd1: r = 9'd31;
      4'd2: r = 9'd61;
      4'd3: r = 9'd92;
      4'd4: r = 9'd122;
      4'd5: r = 9'd153;
      4'd6: r = 9'd184;
      4'd7: r = 9'd214;
      4'd8: r = 9'd245;
      4'd9: r = 9'd275;
      4'd10: r = 9'd306;
      4'd11: r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] mod7(input logic [22:0] x);
    logic [23:0] w;
    logic [5:0]  s;
    logic [3:0]  t;
    w = {1'b0, x};
    s = '0;
    for (int i = 0; i < 8; i++) s = s + 6'(w[3*i +: 3]);
    t = 4'(s[5:3]) + 4'(s[2:0]);
    if (t >= 4'd7) t = t - 4'd7;
    if (t >= 4'd7) t = t - 4'd7;
    return t[2:0];
  endfunction

endpackage

[src/gdn_jdn2date.sv]
`timescale 1ns / 1ps
// Six-stage pipeline turning a Julian day number into date, weekday and year data.
// Depends on gdn_pkg.
module gdn_jdn2date (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gdn_pkg::gdn_jd_t  in_jd,
  output logic              out_valid,
  input  logic              out_stall,
  output gdn_pkg::gdn_out_t out_data
);
  import gdn_pkg::*;

  localparam logic [14:0] KB = 15'((64'd1 << 32) / 64'd146097);
  localparam logic [21:0] KC = 22'((64'd1 << 32) / 64'd1461);

  logic h1, h2, h3, h4, h5, h6;

  logic        b1_v_r, b1_ok_r;
  logic [22:0] b1_jd_r;
  logic [24:0] b1_n_r;
  logic [7:0]  b1_b0_r;
  logic [2:0]  b1_wd_r;

  logic        b2_v_r, b2_ok_r;
  logic [22:0] b2_jd_r;
  logic [7:0]  b2_b_r;
  logic [17:0] b2_n2_r;
  logic [2:0]  b2_wd_r;

  logic        b3_v_r, b3_ok_r;
  logic [22:0] b3_jd_r;
  logic [7:0]  b3_b_r;
  logic [17:0] b3_n2_r;
  logic [6:0]  b3_dd0_r;
  logic [2:0]  b3_wd_r;

  logic        b4_v_r, b4_ok_r;
  logic [22:0] b4_jd_r;
  logic [7:0]  b4_b_r;
  logic [6:0]  b4_dd_r;
  logic [8:0]  b4_e_r;
  logic [2:0]  b4_wd_r;

  logic        b5_v_r, b5_ok_r, b5_hi_r;
  logic [22:0] b5_jd_r;
  logic [13:0] b5_y_r;
  logic [3:0]  b5_m_r;
  logic [4:0]  b5_d_r;
  logic [8:0]  b5_e_r;
  logic [2:0]  b5_wd_r;

  logic     b6_v_r;
  gdn_out_t b6_out_r, b6_out_nxt;

  assign h6 = b6_v_r & out_stall;
  assign h5 = b5_v_r & h6;
  assign h4 = b4_v_r & h5;
  assign h3 = b3_v_r & h4;
  assign h2 = b2_v_r & h3;
  assign h1 = b1_v_r & h2;
  assign in_stall = h1;

  logic [22:0] a_c;
  logic [24:0] n_c;
  logic [39:0] p1_c;
  assign a_c  = in_jd.jd + 23'd32044;
  assign n_c  = {a_c, 2'b11};
  assign p1_c = 40'(n_c) * 40'(KB);

  logic [25:0] r_c;
  logic [7:0]  b_c;
  logic [17:0] n2_c;
  always_comb begin
    r_c = 26'(b1_n_r) - 26'(b1_b0_r) * 26'd146097;
    b_c = b1_b0_r;
    if (r_c >= 26'd146097) begin
      r_c = r_c - 26'd146097;
      b_c = b1_b0_r + 8'd1;
    end
    n2_c = {r_c[17:2], 2'b11};
  end

  logic [39:0] p2_c;
  assign p2_c = 40'(b2_n2_r) * 40'(KC);

  logic [17:0] r2_c;
  logic [6:0]  dd_c;
  always_comb begin
    r2_c = b3_n2_r - 18'(b3_dd0_r) * 18'd1461;
    dd_c = b3_dd0_r;
    if (r2_c >= 18'd1461) begin
      r2_c = r2_c - 18'd1461;
      dd_c = b3_dd0_r + 7'd1;
    end
  end

  logic [3:0]  mm_c;
  logic        hi_c;
  logic [8:0]  dm_c;
  logic [15:0] y16_c;
  logic [3:0]  m_c;
  always_comb begin
    mm_c = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (b4_e_r >= mar_offset(4'(k))) mm_c = mm_c + 4'd1;
    end
    hi_c  = (mm_c >= 4'd10);
    dm_c  = b4_e_r - mar_offset(mm_c) + 9'd1;
    m_c   = hi_c ? mm_c - 4'd9 : mm_c + 4'd3;
    y16_c = 16'(b4_b_r) * 16'd100 + 16'(b4_dd_r) + 16'(hi_c) - 16'd4800;
  end

  logic lp_c;
  always_comb begin
    lp_c = is_leap(b5_y_r);
    b6_out_nxt = '0;
    if (b5_ok_r) begin
      b6_out_nxt.valid_res      = 1'b1;
      b6_out_nxt.day_number_out = b5_jd_r;
      b6_out_nxt.year_out       = b5_y_r;
      b6_out_nxt.month_out      = b5_m_r;
      b6_out_nxt.day_out        = b5_d_r;
      b6_out_nxt.weekday        = b5_wd_r + 3'd1;
      b6_out_nxt.day_of_year    = b5_hi_r ? b5_e_r - 9'd305 : b5_e_r + 9'd60 + 9'(lp_c);
      b6_out_nxt.month_length   = month_len(b5_y_r, b5_m_r);
      b6_out_nxt.leap           = lp_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
      b5_v_r <= 1'b0;
      b6_v_r <= 1'b0;
    end else begin
      if (!h1) b1_v_r <= in_valid;
      if (!h2) b2_v_r <= b1_v_r;
      if (!h3) b3_v_r <= b2_v_r;
      if (!h4) b4_v_r <= b3_v_r;
      if (!h5) b5_v_r <= b4_v_r;
      if (!h6) b6_v_r <= b5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!h1) begin
      b1_ok_r <= in_jd.ok;
      b1_jd_r <= in_jd.jd;
      b1_n_r  <= n_c;
      b1_b0_r <= p1_c[39:32];
      b1_wd_r <= mod7(in_jd.jd);
    end
    if (!h2) begin
      b2_ok_r <= b1_ok_r;
      b2_jd_r <= b1_jd_r;
      b2_b_r  <= b_c;
      b2_n2_r <= n2_c;
      b2_wd_r <= b1_wd_r;
    end
    if (!h3) begin
      b3_ok_r  <= b2_ok_r;
      b3_jd_r  <= b2_jd_r;
      b3_b_r   <= b2_b_r;
      b3_n2_r  <= b2_n2_r;
      b3_dd0_r <= p2_c[38:32];
      b3_wd_r  <= b2_wd_r;
    end
    if (!h4) begin
      b4_ok_r <= b3_ok_r;
      b4_jd_r <= b3_jd_r;
      b4_b_r  <= b3_b_r;
      b4_dd_r <= dd_c;
      b4_e_r  <= r2_c[10:2];
      b4_wd_r <= b3_wd_r;
    end
    if (!h5) begin
      b5_ok_r <= b4_ok_r;
      b5_jd_r <= b4_jd_r;
      b5_hi_r <= hi_c;
      b5_y_r  <= y16_c[13:0];
      b5_m_r  <= m_c;
      b5_d_r  <= dm_c[4:0];
      b5_e_r  <= b4_e_r;
      b5_wd_r <= b4_wd_r;
    end
    if (!h6) b6_out_r <= b6_out_nxt;
  end

  assign out_valid = b6_v_r;
  assign out_data  = b6_out_r;

endmodule

[src/gregorian_day_number_converter.sv]
`timescale 1ns / 1ps
// Top level: op decode and date to day number front end, feeding the day number decoder.
// Depends on gdn_pkg and gdn_jdn2date.
//
//  channel | ports                           | beat
//  input   | in_valid, in_stall, in_data     | one op with its date, day number and offset
//  result  | out_valid, out_stall, out_data  | one converted date record per input beat
//
// Eleven register stages: five for op decode and day number, six for the date decode.
// One beat can enter and one can leave every cycle while out_stall is low.
// Stages hold only while the result register is full and stalled; bubbles collapse.
// Reset empties the pipeline; payload registers are not cleared.
module gregorian_day_number_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gdn_pkg::gdn_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gdn_pkg::gdn_out_t out_data
);
  import gdn_pkg::*;

  logic h1, h2, h3, h4, h5, dec_stall;

  logic               s1_v_r, s1_src_ok_r;
  logic [2:0]         s1_op_r;
  logic [13:0]        s1_y_r;
  logic [3:0]         s1_m_r;
  logic [4:0]         s1_d_r;
  logic signed [25:0] s1_tot_r;
  logic signed [24:0] s1_ny_r;
  logic signed [24:0] s1_jd_r;

  logic               s2_v_r, s2_ok_r, s2_isjd_r, s2_clamp_r, s2_check_r;
  logic [13:0]        s2_y_r;
  logic [3:0]         s2_m_r;
  logic [4:0]         s2_d_r;
  logic signed [24:0] s2_jd_r;

  logic               s3_v_r, s3_ok_r, s3_isjd_r;
  logic [14:0]        s3_yy_r;
  logic [3:0]         s3_mm_r;
  logic [4:0]         s3_d_r;
  logic signed [24:0] s3_jd_r;

  logic               s4_v_r, s4_ok_r, s4_isjd_r;
  logic [22:0]        s4_base_r;
  logic [7:0]         s4_q100_r;
  logic signed [24:0] s4_jd_r;

  logic    s5_v_r;
  gdn_jd_t s5_r, s5_nxt;

  assign h5 = s5_v_r & dec_stall;
  assign h4 = s4_v_r & h5;
  assign h3 = s3_v_r & h4;
  assign h2 = s2_v_r & h3;
  assign h1 = s1_v_r & h2;
  assign in_stall = h1;

  logic               src_ok_c;
  logic [17:0]        ym_c;
  logic signed [25:0] tot_c;
  logic signed [24:0] ny_c, jd_c;
  always_comb begin
    src_ok_c = (in_data.year_in >= 14'd1) && (in_data.year_in <= MAX_YEAR) &&
               (in_data.month_in >= 4'd1) && (in_data.month_in <= 4'd12) &&
               (in_data.day_in >= 5'd1) &&
               (in_data.day_in <= month_len(in_data.year_in, in_data.month_in));
    ym_c  = 18'(in_data.year_in) * 18'd12 + 18'(in_data.month_in) - 18'd1;
    tot_c = $signed({8'd0, ym_c}) + $signed({{2{in_data.offset[23]}}, in_data.offset});
    ny_c  = $signed({11'd0, in_data.year_in}) + $signed({in_data.offset[23], in_data.offset});
    if (in_data.op == OP_FROM_JDN) begin
      jd_c = $signed({2'd0, in_data.day_number_in});
    end else begin
      jd_c = $signed({2'd0, in_data.day_number_in}) +
             $signed({in_data.offset[23], in_data.offset});
    end
  end

  logic        tot_ok_c, ny_ok_c;
  logic [31:0] p3_c;
  logic [13:0] q12_c;
  logic [16:0] rem_c;
  logic        ok2_c, isjd2_c, clamp2_c, check2_c;
  logic [13:0] y2_c;
  logic [3:0]  m2_c;
  always_comb begin
    tot_ok_c = (s1_tot_r >= 26'sd12) && (s1_tot_r < 26'sd120000);
    ny_ok_c  = (s1_ny_r >= 25'sd1) && (s1_ny_r <= 25'sd9999);
    p3_c     = 32'(s1_tot_r[16:2]) * 32'd43691;
    q12_c    = p3_c[30:17];
    rem_c    = s1_tot_r[16:0] - 17'(q12_c) * 17'd12;
    ok2_c    = 1'b0;
    isjd2_c  = 1'b0;
    clamp2_c = 1'b0;
    check2_c = 1'b0;
    y2_c     = s1_y_r;
    m2_c     = s1_m_r;
    case (s1_op_r)
      OP_FROM_DATE: ok2_c = s1_src_ok_r;
      OP_FROM_JDN, OP_ADD_DAYS: isjd2_c = 1'b1;
      OP_ADD_MONTHS: begin
        ok2_c    = s1_src_ok_r && tot_ok_c;
        clamp2_c = 1'b1;
        y2_c     = q12_c;
        m2_c     = rem_c[3:0] + 4'd1;
      end
      OP_ADD_YEARS: begin
        ok2_c    = s1_src_ok_r && ny_ok_c;
        check2_c = 1'b1;
        y2_c     = s1_ny_r[13:0];
      end
      default: ok2_c = 1'b0;
    endcase
  end

  logic [4:0]  lim_c, d3_c;
  logic        ok3_c, early_c;
  logic [14:0] yy_c;
  logic [3:0]  mm_c;
  always_comb begin
    lim_c   = month_len(s2_y_r, s2_m_r);
    d3_c    = (s2_clamp_r && (s2_d_r > lim_c)) ? lim_c : s2_d_r;
    ok3_c   = s2_ok_r && !(s2_check_r && (s2_d_r > lim_c));
    early_c = (s2_m_r <= 4'd2);
    yy_c    = 15'(s2_y_r) + 15'd4800 - 15'(early_c);
    mm_c    = early_c ? s2_m_r + 4'd9 : s2_m_r - 4'd3;
  end

  logic [12:0] yq_c;
  logic [25:0] p4_c;
  logic [22:0] base_c;
  always_comb begin
    yq_c   = s3_yy_r[14:2];
    p4_c   = 26'(yq_c) * 26'd5243;
    base_c = 23'(s3_yy_r) * 23'd365 + 23'(yq_c) + 23'(s3_d_r) + 23'(mar_offset(s3_mm_r));
  end

  always_comb begin
    if (s4_isjd_r) begin
      s5_nxt.jd = s4_jd_r[22:0];
      s5_nxt.ok = (s4_jd_r >= $signed({2'd0, FIRST_JDN})) &&
                  (s4_jd_r <= $signed({2'd0, LAST_JDN}));
    end else begin
      s5_nxt.jd = s4_base_r - 23'(s4_q100_r) + 23'(s4_q100_r[7:2]) - 23'd32045;
      s5_nxt.ok = s4_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (!h1) s1_v_r <= in_valid;
      if (!h2) s2_v_r <= s1_v_r;
      if (!h3) s3_v_r <= s2_v_r;
      if (!h4) s4_v_r <= s3_v_r;
      if (!h5) s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!h1) begin
      s1_src_ok_r <= src_ok_c;
      s1_op_r     <= in_data.op;
      s1_y_r      <= in_data.year_in;
      s1_m_r      <= in_data.month_in;
      s1_d_r      <= in_data.day_in;
      s1_tot_r    <= tot_c;
      s1_ny_r     <= ny_c;
      s1_jd_r     <= jd_c;
    end
    if (!h2) begin
      s2_ok_r    <= ok2_c;
      s2_isjd_r  <= isjd2_c;
      s2_clamp_r <= clamp2_c;
      s2_check_r <= check2_c;
      s2_y_r     <= y2_c;
      s2_m_r     <= m2_c;
      s2_d_r     <= s1_d_r;
      s2_jd_r    <= s1_jd_r;
    end
    if (!h3) begin
      s3_ok_r   <= ok3_c;
      s3_isjd_r <= s2_isjd_r;
      s3_yy_r   <= yy_c;
      s3_mm_r   <= mm_c;
      s3_d_r    <= d3_c;
      s3_jd_r   <= s2_jd_r;
    end
    if (!h4) begin
      s4_ok_r   <= s3_ok_r;
      s4_isjd_r <= s3_isjd_r;
      s4_base_r <= base_c;
      s4_q100_r <= p4_c[24:17];
      s4_jd_r   <= s3_jd_r;
    end
    if (!h5) s5_r <= s5_nxt;
  end

  gdn_jdn2date u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s5_v_r),
    .in_stall  (dec_stall),
    .in_jd     (s5_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res |->
      out_data.year_out >= 14'd1 && out_data.year_out <= MAX_YEAR &&
      out_data.month_out >= 4'd1 && out_data.month_out <= 4'd12)
    else $error("valid result with date out of range");

  a_valid_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res |->
      out_data.day_out >= 5'd1 && out_data.day_out <= out_data.month_length &&
      out_data.weekday != 3'd0)
    else $error("valid result with bad day or weekday");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |->
      out_data.day_number_out == 23'd0 && out_data.weekday == 3'd0 &&
      out_data.year_out == 14'd0)
    else $error("invalid result not cleared");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && s5_v_r)
    else $error("input stalled with a bubble in the pipeline");

endmodule
